/* rtl/core/crb_pkg.sv */
package crb_pkg;

  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned POS_W         = 12;
  localparam int unsigned DIM_REG_W     = 13;
  localparam int unsigned PIXEL_W       = 32;
  localparam int unsigned INDEX_W       = 24;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 13;

  localparam logic [DIM_REG_W-1:0] FB_WIDTH_RST  = 13'd400;
  localparam logic [DIM_REG_W-1:0] FB_HEIGHT_RST = 13'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_X      = 3'd0,
    CFG_DEST_Y      = 3'd1,
    CFG_RECT_WIDTH  = 3'd2,
    CFG_RECT_HEIGHT = 3'd3,
    CFG_FB_WIDTH    = 3'd4,
    CFG_FB_HEIGHT   = 3'd5
  } cfg_idx_e;

  // Current register set plus the precomputed index of the rectangle's top row.
  typedef struct packed {
    logic [POS_W-1:0]     dest_x;
    logic [POS_W-1:0]     dest_y;
    logic [DIM_REG_W-1:0] rect_width;
    logic [DIM_REG_W-1:0] rect_height;
    logic [DIM_REG_W-1:0] fb_width;
    logic [DIM_REG_W-1:0] fb_height;
    logic [INDEX_W-1:0]   top_base;
  } cfg_t;

  typedef struct packed {
    logic               write_enable;
    logic [INDEX_W-1:0] fb_index;
    logic [PIXEL_W-1:0] fb_pixel;
    logic               rect_done;
  } res_t;

endpackage

/* rtl/core/crb_cfg_regs.sv */
module crb_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [crb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output crb_pkg::cfg_t                     cfg_o
);

  logic [crb_pkg::POS_W-1:0]     dest_x_q, dest_y_q, dest_y_d;
  logic [crb_pkg::DIM_REG_W-1:0] rect_width_q, rect_height_q, fb_width_q, fb_height_q;
  logic [crb_pkg::DIM_REG_W-1:0] fb_width_d;
  logic [crb_pkg::INDEX_W-1:0]   top_base_q;
  logic [crb_pkg::POS_W+crb_pkg::DIM_REG_W-1:0] top_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q      <= '0;
      dest_y_q      <= '0;
      rect_width_q  <= '0;
      rect_height_q <= '0;
      fb_width_q    <= crb_pkg::FB_WIDTH_RST;
      fb_height_q   <= crb_pkg::FB_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (crb_pkg::cfg_idx_e'(cfg_idx_i))
        crb_pkg::CFG_DEST_X:      dest_x_q      <= cfg_wdata_i[crb_pkg::POS_W-1:0];
        crb_pkg::CFG_DEST_Y:      dest_y_q      <= cfg_wdata_i[crb_pkg::POS_W-1:0];
        crb_pkg::CFG_RECT_WIDTH:  rect_width_q  <= cfg_wdata_i;
        crb_pkg::CFG_RECT_HEIGHT: rect_height_q <= cfg_wdata_i;
        crb_pkg::CFG_FB_WIDTH:    fb_width_q    <= cfg_wdata_i;
        crb_pkg::CFG_FB_HEIGHT:   fb_height_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dest_y_d   = dest_y_q;
    fb_width_d = fb_width_q;
    if (cfg_we_i && (crb_pkg::cfg_idx_e'(cfg_idx_i) == crb_pkg::CFG_DEST_Y)) begin
      dest_y_d = cfg_wdata_i[crb_pkg::POS_W-1:0];
    end
    if (cfg_we_i && (crb_pkg::cfg_idx_e'(cfg_idx_i) == crb_pkg::CFG_FB_WIDTH)) begin
      fb_width_d = cfg_wdata_i;
    end
  end

  // The top row index is registered from the next register values, so it is
  // ready together with the registers for the first word after a write.
  assign top_prod = (crb_pkg::POS_W+crb_pkg::DIM_REG_W)'(dest_y_d)
                  * (crb_pkg::POS_W+crb_pkg::DIM_REG_W)'(fb_width_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_base_q <= '0;
    end else begin
      top_base_q <= top_prod[crb_pkg::INDEX_W-1:0];
    end
  end

  assign cfg_o.dest_x      = dest_x_q;
  assign cfg_o.dest_y      = dest_y_q;
  assign cfg_o.rect_width  = rect_width_q;
  assign cfg_o.rect_height = rect_height_q;
  assign cfg_o.fb_width    = fb_width_q;
  assign cfg_o.fb_height   = fb_height_q;
  assign cfg_o.top_base    = top_base_q;

endmodule

/* rtl/core/crb_addr_gen.sv */
module crb_addr_gen #(
  parameter int unsigned MAX_DIM = crb_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  crb_pkg::cfg_t                   cfg_i,
  input  logic                            restart_i,
  input  logic                            step_i,
  input  logic [crb_pkg::PIXEL_W-1:0]     pixel_i,
  output crb_pkg::res_t                   res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = (DIM_W > crb_pkg::DIM_REG_W) ? DIM_W : crb_pkg::DIM_REG_W;
  localparam int unsigned SUM_W = ((CNT_W > crb_pkg::POS_W) ? CNT_W : crb_pkg::POS_W) + 1;
  localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

  logic [CNT_W-1:0]            col_q, col_d, row_q, row_d;
  logic [crb_pkg::INDEX_W-1:0] row_off_q, row_off_d;
  logic [DIM_W-1:0]            w_eff, h_eff, col_inc, row_inc;
  logic [CMP_W-1:0]            w_ext, h_ext;
  logic [SUM_W-1:0]            fb_col, fb_row;
  logic                        empty, in_clip, col_wrap, row_wrap;

  assign w_ext = CMP_W'(cfg_i.rect_width);
  assign h_ext = CMP_W'(cfg_i.rect_height);
  assign w_eff = (w_ext > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : DIM_W'(w_ext);
  assign h_eff = (h_ext > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : DIM_W'(h_ext);
  assign empty = (w_eff == '0) || (h_eff == '0);

  assign fb_col = SUM_W'(cfg_i.dest_x) + SUM_W'(col_q);
  assign fb_row = SUM_W'(cfg_i.dest_y) + SUM_W'(row_q);
  assign in_clip = !empty && (fb_col < SUM_W'(cfg_i.fb_width))
                && (fb_row < SUM_W'(cfg_i.fb_height));

  assign col_inc  = DIM_W'(col_q) + DIM_W'(1);
  assign row_inc  = DIM_W'(row_q) + DIM_W'(1);
  assign col_wrap = col_inc >= w_eff;
  assign row_wrap = row_inc >= h_eff;

  always_comb begin
    res_o.write_enable = in_clip;
    res_o.fb_index     = '0;
    res_o.fb_pixel     = '0;
    res_o.rect_done    = empty || (col_wrap && row_wrap);
    if (in_clip) begin
      res_o.fb_index = cfg_i.top_base + row_off_q
                     + crb_pkg::INDEX_W'(cfg_i.dest_x) + crb_pkg::INDEX_W'(col_q);
      res_o.fb_pixel = pixel_i;
    end
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    row_off_d = row_off_q;
    if (restart_i || (step_i && (empty || (col_wrap && row_wrap)))) begin
      col_d     = '0;
      row_d     = '0;
      row_off_d = '0;
    end else if (step_i) begin
      if (col_wrap) begin
        col_d     = '0;
        row_d     = row_inc[CNT_W-1:0];
        row_off_d = row_off_q + crb_pkg::INDEX_W'(cfg_i.fb_width);
      end else begin
        col_d = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      row_off_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      row_off_q <= row_off_d;
    end
  end

endmodule

/* rtl/core/clipped_rect_blit_top.sv */
// Rectangle blit into a linear framebuffer, with clipping.
// The input channel carries one source pixel word per handshake, in row-major
// order over the configured rectangle. The output channel returns one word per
// pixel: the framebuffer word index, the pixel, a write enable that is low for
// pixels outside the framebuffer (index and pixel are then zero), and a done
// flag on the last pixel of the rectangle.
// The user must write registers through the cfg port only while no word is in
// flight (not enforced); each write restarts the rectangle at its first pixel.
// From input handshake to output valid a word passes the input register, then
// the clip and address logic into the output register.
// Throughput is one word per cycle while the receiver does not stall; the
// column and row counters and the row base add advance once per word.
// When the receiver stalls, the output word holds and the input side stalls
// as soon as the input register is also occupied.
// Reset clears the valid flags of both pipeline stages and the counters, and
// loads the register reset values (400 by 300 framebuffer, empty rectangle).
module clipped_rect_blit_top #(
  parameter int unsigned MAX_DIM = crb_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [crb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [crb_pkg::PIXEL_W-1:0]     src_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            write_enable_o,
  output logic [crb_pkg::INDEX_W-1:0]     fb_index_o,
  output logic [crb_pkg::PIXEL_W-1:0]     fb_pixel_o,
  output logic                            rect_done_o
);

  crb_pkg::cfg_t               cfg;
  crb_pkg::res_t               res, out_res_q;
  logic                        in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic [crb_pkg::PIXEL_W-1:0] in_pixel_q;
  logic                        advance, move, in_take;

  crb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  crb_addr_gen #(
    .MAX_DIM (MAX_DIM)
  ) u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (cfg_we_i),
    .step_i    (move),
    .pixel_i   (in_pixel_q),
    .res_o     (res)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign move       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (move) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_pixel_q <= src_pixel_i;
    end
    if (move) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = out_res_q.write_enable;
  assign fb_index_o     = out_res_q.fb_index;
  assign fb_pixel_o     = out_res_q.fb_pixel;
  assign rect_done_o    = out_res_q.rect_done;

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (fb_index_o == '0 && fb_pixel_o == '0))
    else $error("dropped pixel carries a nonzero index or pixel");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output stage could advance");

  a_take_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_valid_q)
    else $error("accepted word lost from the input register");

  a_move_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_stall_o) |=> out_valid_o)
    else $error("word leaving the input register did not reach the output");

endmodule
